/* design/ssie_pkg.sv */
// shared types and constants for the sorted set insert engine
// no dependencies; imported by ssie_cell and sorted_set_insert_engine
`timescale 1ns / 1ps

package ssie_pkg;

    // default sizing
    localparam int CAPACITY_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_COMPARE,
        S_APPLY
    } state_t;

    // request fields
    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] attribute;
        logic [5:0]  read_index;
    } request_t;

    // result fields
    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  element_count;
        logic [31:0] read_value;
    } result_t;

    // controls broadcast to every cell
    typedef struct packed {
        logic compare;
        logic apply;
    } cell_ctrl_t;

endpackage

/* design/sorted_set_insert_engine.sv */
// top level of the sorted set insert engine: controller and row of cells
// depends on ssie_pkg and ssie_cell
`timescale 1ns / 1ps

// Keeps up to CAPACITY distinct numbers in ascending order.
// Request channel: present request while busy is low and raise start; the
// request is taken at that clock edge. operation selects insert, read or
// clear; attribute is the number to insert; read_index the position to read.
// Result channel: done is high for exactly one cycle with result valid;
// status, element_count (count after the request) and read_value.
// After the accepting edge every cell compares its entry with the key in
// the compare state, and in the apply state that follows the controller
// reduces the cell flags and the row shifts; done rises at the edge that
// ends the apply state. The next request can be accepted at the edge that
// ends the done cycle, so no request is taken while the last is in flight.
// Reset empties the set (count zero) and leaves busy and done low.
// Entry contents are not cleared; only positions below the count are read.
// The receiver cannot stall: a result is shown once and must be taken.
module sorted_set_insert_engine #(
    parameter int CAPACITY    = ssie_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = ssie_pkg::VALUE_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ssie_pkg::request_t  request,
    output logic                done,
    output ssie_pkg::result_t   result
);
    import ssie_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

    state_t                 state_reg;
    state_t                 state_next;
    request_t               req_reg;
    logic [VALUE_WIDTH-1:0] key_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    result_t                result_reg;
    result_t                result_next;
    logic                   done_reg;
    logic                   done_next;
    cell_ctrl_t             ctrl;

    logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
    logic [CAPACITY:0]      lt_chain;
    logic [CAPACITY-1:0]    eq_vec;
    logic [IDX_W-1:0]       idx_sel;
    logic                   accept;
    logic                   dup;
    logic                   full;
    logic                   in_range;

    assign accept = start && (state_reg == S_IDLE);

    // request latch
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
            key_reg <= VALUE_WIDTH'(request.attribute);
        end
    end

    // row of cells; left of cell zero always counts as below the key
    assign lt_chain[0] = 1'b1;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0] left_value;

        if (i == 0)
        begin : g_first
            assign left_value = key_reg;
        end
        else
        begin : g_rest
            assign left_value = cell_value[i-1];
        end

        ssie_cell #(
            .CAPACITY    (CAPACITY),
            .VALUE_WIDTH (VALUE_WIDTH),
            .INDEX       (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .key        (key_reg),
            .count      (count_reg),
            .left_value (left_value),
            .left_lt    (lt_chain[i]),
            .value      (cell_value[i]),
            .lt         (lt_chain[i+1]),
            .eq         (eq_vec[i])
        );
    end

    // flag reduction and read selection
    assign dup      = |eq_vec;
    assign full     = count_reg == CNT_W'(CAPACITY);
    assign idx_sel  = IDX_W'(req_reg.read_index);
    assign in_range = CMP_W'(req_reg.read_index) < CMP_W'(count_reg);

    // controller: next state, cell controls and result
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        ctrl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_COMPARE;
                end
            end
            S_COMPARE:
            begin
                ctrl.compare = 1'b1;
                state_next   = S_APPLY;
            end
            S_APPLY:
            begin
                state_next             = S_IDLE;
                done_next              = 1'b1;
                result_next.status     = ST_DONE;
                result_next.read_value = '0;
                case (req_reg.operation)
                    OP_INSERT:
                    begin
                        if (dup)
                        begin
                            result_next.status = ST_DUP;
                        end
                        else if (full)
                        begin
                            result_next.status = ST_FULL;
                        end
                        else
                        begin
                            ctrl.apply = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    OP_READ:
                    begin
                        if (in_range)
                        begin
                            result_next.read_value = 32'(cell_value[idx_sel]);
                        end
                        else
                        begin
                            result_next.status = ST_RANGE;
                        end
                    end
                    OP_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                        count_next = count_reg;
                    end
                endcase
                result_next.element_count = 7'(count_next);
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

    // a result appears only right after the apply cycle
    a_done_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_APPLY))
        else $error("result strobe without apply cycle");

    // count never passes capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    // sorted row: below-key flags form a prefix
    a_lt_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |->
            ((lt_chain[CAPACITY:1] >> 1) & ~lt_chain[CAPACITY:1]) == '0)
        else $error("below-key flags not a prefix");

    // no duplicate entries held
    a_eq_single: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |-> $onehot0(eq_vec))
        else $error("key matches more than one entry");

endmodule

/* design/ssie_cell.sv */
// one slot of the sorted row: holds an entry, compares it with the key
// and takes the key or its left neighbor's entry on insert; uses ssie_pkg
`timescale 1ns / 1ps

module ssie_cell #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32,
    parameter int INDEX       = 0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ssie_pkg::cell_ctrl_t           ctrl,
    input  logic [VALUE_WIDTH-1:0]         key,
    input  logic [$clog2(CAPACITY+1)-1:0]  count,
    input  logic [VALUE_WIDTH-1:0]         left_value,
    input  logic                           left_lt,
    output logic [VALUE_WIDTH-1:0]         value,
    output logic                           lt,
    output logic                           eq
);
    import ssie_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic                   lt_reg;
    logic                   lt_next;
    logic                   eq_reg;
    logic                   eq_next;
    logic                   valid;

    // slot holds a live entry when its index is below the count
    assign valid = CNT_W'(INDEX) < count;

    // compare stage: entry below key, entry equal to key
    always_comb
    begin
        lt_next = lt_reg;
        eq_next = eq_reg;
        if (ctrl.compare)
        begin
            lt_next = valid && (value_reg < key);
            eq_next = valid && (value_reg == key);
        end
    end

    // insert: slots at or above the insert point move up by one
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.apply && !lt_reg)
        begin
            if (left_lt)
            begin
                value_next = key;
            end
            else
            begin
                value_next = left_value;
            end
        end
    end

    // flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else
        begin
            lt_reg <= lt_next;
            eq_reg <= eq_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule
